// File: hdl/hsv2rgb_pkg.sv
// ============================================================================
// HSV to RGB package
// Shared types, stage payloads and constants for the HSV to RGB converter.
// ============================================================================
package hsv2rgb_pkg;

    // Default number of fraction bits in the hue input
    localparam int HUE_FRAC_BITS_DEFAULT = 16;

    // Unity in Q.16, as wide as the clamped saturation and value
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Alpha byte of every packed pixel
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Hue sector, the integer part of hue times six
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW     = 3'd0,
        SECTOR_YELLOW_GREEN   = 3'd1,
        SECTOR_GREEN_CYAN     = 3'd2,
        SECTOR_CYAN_BLUE      = 3'd3,
        SECTOR_BLUE_MAGENTA   = 3'd4,
        SECTOR_MAGENTA_RED    = 3'd5
    } sector_t;

    // Input item
    typedef struct packed {
        logic signed [31:0] hue;
        logic signed [15:0] saturation;
        logic signed [15:0] brightness;
    } hsv_item_t;

    // Result item
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] argb_pixel;
    } rgb_item_t;

    // After hue split and clamping
    typedef struct packed {
        sector_t     sector;
        logic [15:0] f;
        logic [16:0] s;
        logic [16:0] v;
    } prep_t;

    // After the first row of products
    typedef struct packed {
        sector_t     sector;
        logic [16:0] v;
        logic [16:0] p;
        logic [15:0] fs;
        logic [16:0] gs;
    } prod_t;

    // All candidate channel levels
    typedef struct packed {
        sector_t     sector;
        logic [16:0] v;
        logic [16:0] p;
        logic [16:0] q;
        logic [16:0] t;
    } level_t;

endpackage

// File: hdl/hsv2rgb_prep.sv
// ============================================================================
// HSV to RGB hue split stage
// Wraps the hue, forms sector and fraction, clamps saturation and value.
// ============================================================================
module hsv2rgb_prep
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  hsv_item_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output prep_t     dn_data
);

    localparam logic [31:0] HueMask = (32'd1 << HUE_FRAC_BITS) - 32'd1;
    localparam int ShiftRight = (HUE_FRAC_BITS >= 16) ? HUE_FRAC_BITS - 16 : 0;
    localparam int ShiftLeft  = (HUE_FRAC_BITS < 16) ? 16 - HUE_FRAC_BITS : 0;

    logic        valid_reg;
    prep_t       data_reg;
    prep_t       data_next;
    logic [31:0] hue_masked;
    logic [15:0] h16;
    logic [18:0] h6;

    function automatic logic [16:0] clamp_unit(input logic signed [15:0] x);
        logic [8:0] c;
        if (x < 16'sd0)
            c = 9'd0;
        else if (x > 16'sd256)
            c = 9'd256;
        else
            c = x[8:0];
        return {c, 8'd0};
    endfunction

    always_comb
    begin
        hue_masked = up_data.hue & HueMask;
        h16        = 16'((hue_masked >> ShiftRight) << ShiftLeft);
        // times six as (x << 2) + (x << 1)
        h6         = {1'b0, h16, 2'b00} + {2'b00, h16, 1'b0};
        data_next.sector = sector_t'(h6[18:16]);
        data_next.f      = h6[15:0];
        data_next.s      = clamp_unit(up_data.saturation);
        data_next.v      = clamp_unit(up_data.brightness);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/hsv2rgb_mul1.sv
// ============================================================================
// HSV to RGB first product stage
// Forms p = v(1-s), f*s and (1-f)*s in Q.16.
// ============================================================================
module hsv2rgb_mul1
    import hsv2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  prep_t up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output prod_t dn_data
);

    logic        valid_reg;
    prod_t       data_reg;
    prod_t       data_next;
    logic [33:0] p_full;
    logic [32:0] fs_full;
    logic [33:0] gs_full;
    logic [16:0] one_minus_f;

    always_comb
    begin
        one_minus_f = ONE_Q16 - {1'b0, up_data.f};
        p_full      = 34'(up_data.v) * 34'(ONE_Q16 - up_data.s);
        fs_full     = 33'(up_data.f) * 33'(up_data.s);
        gs_full     = 34'(one_minus_f) * 34'(up_data.s);
        data_next.sector = up_data.sector;
        data_next.v      = up_data.v;
        data_next.p      = p_full[32:16];
        data_next.fs     = fs_full[31:16];
        data_next.gs     = gs_full[32:16];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/hsv2rgb_mul2.sv
// ============================================================================
// HSV to RGB second product stage
// Forms q = v(1-fs) and t = v(1-(1-f)s) in Q.16.
// ============================================================================
module hsv2rgb_mul2
    import hsv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  prod_t  up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output level_t dn_data
);

    logic        valid_reg;
    level_t      data_reg;
    level_t      data_next;
    logic [33:0] q_full;
    logic [33:0] t_full;

    always_comb
    begin
        q_full = 34'(up_data.v) * 34'(ONE_Q16 - {1'b0, up_data.fs});
        t_full = 34'(up_data.v) * 34'(ONE_Q16 - up_data.gs);
        data_next.sector = up_data.sector;
        data_next.v      = up_data.v;
        data_next.p      = up_data.p;
        data_next.q      = q_full[32:16];
        data_next.t      = t_full[32:16];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/hsv2rgb_route.sv
// ============================================================================
// HSV to RGB routing stage
// Routes levels to channels by sector, scales to bytes and packs the pixel.
// ============================================================================
module hsv2rgb_route
    import hsv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  level_t    up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output rgb_item_t dn_data
);

    logic        valid_reg;
    rgb_item_t   data_reg;
    rgb_item_t   data_next;
    logic [16:0] r_level;
    logic [16:0] g_level;
    logic [16:0] b_level;
    logic [7:0]  r_byte;
    logic [7:0]  g_byte;
    logic [7:0]  b_byte;

    // level * 255 >> 16; a level of at most 1.0 never exceeds 255
    function automatic logic [7:0] to_byte(input logic [16:0] level);
        logic [24:0] scaled;
        scaled = {level, 8'd0} - 25'(level);
        return scaled[23:16];
    endfunction

    always_comb
    begin
        case (up_data.sector)
            SECTOR_RED_YELLOW:
            begin
                r_level = up_data.v;
                g_level = up_data.t;
                b_level = up_data.p;
            end
            SECTOR_YELLOW_GREEN:
            begin
                r_level = up_data.q;
                g_level = up_data.v;
                b_level = up_data.p;
            end
            SECTOR_GREEN_CYAN:
            begin
                r_level = up_data.p;
                g_level = up_data.v;
                b_level = up_data.t;
            end
            SECTOR_CYAN_BLUE:
            begin
                r_level = up_data.p;
                g_level = up_data.q;
                b_level = up_data.v;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                r_level = up_data.t;
                g_level = up_data.p;
                b_level = up_data.v;
            end
            default:
            begin
                r_level = up_data.v;
                g_level = up_data.p;
                b_level = up_data.q;
            end
        endcase

        r_byte = to_byte(r_level);
        g_byte = to_byte(g_level);
        b_byte = to_byte(b_level);

        data_next.red        = r_byte;
        data_next.green      = g_byte;
        data_next.blue       = b_byte;
        data_next.argb_pixel = {ALPHA_OPAQUE, r_byte, g_byte, b_byte};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// ============================================================================
// HSV to RGB converter
// Converts one fixed-point HSV color to RGB bytes and a packed ARGB pixel.
// ============================================================================
// Usage: present one HSV color per transfer on the hsv channel and collect one
// RGB result per transfer on the rgb channel, in the same order. The block
// takes one color every clock cycle while the rgb side does not stall. A
// color passes through four register stages in order (hue split and clamp,
// first products, second products, routing and byte scaling), and the two
// rows of dependent products of up to 17x17 bits set the stage depth. Hue
// is signed with HUE_FRAC_BITS fraction bits and only its fraction is used,
// so any whole number of turns wraps away. Saturation and brightness are
// signed Q8.8 and clamp to 0..1.0. The pixel carries alpha 0xFF in its top
// byte. Stalling the rgb side backs up the stages one by one; empty stages
// keep filling, so nothing is dropped or repeated.
// ============================================================================
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,

    // HSV color in
    input  logic      hsv_valid,
    output logic      hsv_stall,
    input  hsv_item_t hsv,

    // RGB result out
    output logic      rgb_valid,
    input  logic      rgb_stall,
    output rgb_item_t rgb
);

    logic   prep_ready;
    logic   prep_valid;
    prep_t  prep_data;
    logic   prod_ready;
    logic   prod_valid;
    prod_t  prod_data;
    logic   level_ready;
    logic   level_valid;
    level_t level_data;
    logic   route_ready;

    // Stage 1: wrap hue, split into sector and fraction, clamp s and v
    hsv2rgb_prep #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hsv_valid),
        .up_ready (prep_ready),
        .up_data  (hsv),
        .dn_valid (prep_valid),
        .dn_ready (prod_ready),
        .dn_data  (prep_data)
    );

    // Stage 2: p, and the saturation products that feed q and t
    hsv2rgb_mul1 u_mul1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prep_valid),
        .up_ready (prod_ready),
        .up_data  (prep_data),
        .dn_valid (prod_valid),
        .dn_ready (level_ready),
        .dn_data  (prod_data)
    );

    // Stage 3: q and t, scaled by value
    hsv2rgb_mul2 u_mul2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (level_ready),
        .up_data  (prod_data),
        .dn_valid (level_valid),
        .dn_ready (route_ready),
        .dn_data  (level_data)
    );

    // Stage 4: route by sector, scale to bytes, hold the result for transfer
    hsv2rgb_route u_route (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (level_valid),
        .up_ready (route_ready),
        .up_data  (level_data),
        .dn_valid (rgb_valid),
        .dn_ready (!rgb_stall),
        .dn_data  (rgb)
    );

    // Stall the source only when the first stage is full and cannot advance
    assign hsv_stall = !prep_ready;

endmodule
